// ===== rtl/ordered_array_list_engine_macros.svh =====
// ----------------------------------------------------------------------------
// ordered array list engine assertion macros
// shared concurrent assertion forms, clocked on the rising edge, off in reset
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define OALE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OALE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/oale_pkg.sv =====
// ----------------------------------------------------------------------------
// oale_pkg
// types, codes and defaults shared by the ordered array list engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oale_pkg;

    // default sizing
    localparam int DEPTH_DEF      = 128;
    localparam int NAME_BYTES_DEF = 8;

    // failure text "N/A", first character in the low byte
    localparam logic [63:0] NA_TEXT = 64'h0000_0000_0041_2F4E;
    localparam logic [31:0] ID_FAIL = 32'hFFFF_FFFF;

    // opcodes
    localparam logic [3:0] OP_INS_FRONT  = 4'd0;
    localparam logic [3:0] OP_INS_END    = 4'd1;
    localparam logic [3:0] OP_INS_AFTER  = 4'd2;
    localparam logic [3:0] OP_INS_BEFORE = 4'd3;
    localparam logic [3:0] OP_REM_FRONT  = 4'd4;
    localparam logic [3:0] OP_REM_END    = 4'd5;
    localparam logic [3:0] OP_REM_ITEM   = 4'd6;
    localparam logic [3:0] OP_FIND_ID    = 4'd7;
    localparam logic [3:0] OP_FIND_NAME  = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // request word
    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] new_id;
        logic [63:0]        new_name;
        logic signed [31:0] key_id;
        logic [63:0]        key_name;
    } req_word_t;

    // response word
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_id;
        logic [63:0]        out_name;
        logic [7:0]         entry_count;
    } rsp_word_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT_UP,
        S_WRITE,
        S_FETCH,
        S_FETCH_CAP,
        S_SHIFT_DN,
        S_FINISH
    } state_t;

    // memory read address source
    typedef enum logic [1:0] {
        RD_FWD,
        RD_BACK,
        RD_POS
    } rd_mode_t;

    // memory write source
    typedef enum logic [1:0] {
        WR_NONE,
        WR_UP,
        WR_DOWN,
        WR_ITEM
    } wr_mode_t;

    // pointer load source
    typedef enum logic [1:0] {
        PTR_ZERO,
        PTR_FILL,
        PTR_HIT_NEXT,
        PTR_POS_NEXT
    } ptr_sel_t;

    // position load source
    typedef enum logic [2:0] {
        POS_ZERO,
        POS_FILL,
        POS_LAST,
        POS_HIT,
        POS_HIT_NEXT
    } pos_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       rd_en;
        rd_mode_t   rd_mode;
        wr_mode_t   wr_mode;
        logic       ptr_ld;
        ptr_sel_t   ptr_sel;
        logic       pos_ld;
        pos_sel_t   pos_sel;
        logic       cap_hit;
        logic       fill_inc;
        logic       fill_dec;
        logic       st_ld;
        logic [1:0] st_code;
        logic       res_ld;
    } oale_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [3:0] opcode;
        logic       fill_zero;
        logic       fill_full;
        logic       hit;
        logic       miss;
        logic       ptr_lt_fill;
        logic       ptr_gt_pos;
        logic       rd_vld;
        logic       res_free;
    } oale_stat_t;

endpackage

// ===== rtl/oale_ctrl.sv =====
// ----------------------------------------------------------------------------
// oale_ctrl
// sequencer for the list engine: scan, shift, write and respond steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oale_ctrl
    import oale_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  oale_stat_t stat,
    output oale_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // take a request word only when idle
    assign req_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.st_ld   = 1'b1;
                    cmd.st_code = ST_OK;
                    state_next  = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                case (stat.opcode)
                    OP_INS_FRONT, OP_INS_END:
                    begin
                        if (stat.fill_full)
                        begin
                            cmd.st_ld   = 1'b1;
                            cmd.st_code = ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            cmd.pos_ld  = 1'b1;
                            cmd.pos_sel = (stat.opcode == OP_INS_FRONT) ? POS_ZERO : POS_FILL;
                            cmd.ptr_ld  = 1'b1;
                            cmd.ptr_sel = PTR_FILL;
                            state_next  = S_SHIFT_UP;
                        end
                    end
                    OP_INS_AFTER, OP_INS_BEFORE, OP_REM_ITEM, OP_FIND_ID, OP_FIND_NAME:
                    begin
                        cmd.ptr_ld  = 1'b1;
                        cmd.ptr_sel = PTR_ZERO;
                        state_next  = S_SCAN;
                    end
                    OP_REM_FRONT, OP_REM_END:
                    begin
                        if (stat.fill_zero)
                        begin
                            cmd.st_ld   = 1'b1;
                            cmd.st_code = ST_EMPTY;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            cmd.pos_ld  = 1'b1;
                            cmd.pos_sel = (stat.opcode == OP_REM_FRONT) ? POS_ZERO : POS_LAST;
                            state_next  = S_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (stat.hit)
                begin
                    case (stat.opcode)
                        OP_INS_AFTER, OP_INS_BEFORE:
                        begin
                            if (stat.fill_full)
                            begin
                                cmd.st_ld   = 1'b1;
                                cmd.st_code = ST_FULL;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                cmd.pos_ld  = 1'b1;
                                cmd.pos_sel = (stat.opcode == OP_INS_AFTER) ?
                                              POS_HIT_NEXT : POS_HIT;
                                cmd.ptr_ld  = 1'b1;
                                cmd.ptr_sel = PTR_FILL;
                                state_next  = S_SHIFT_UP;
                            end
                        end
                        OP_REM_ITEM:
                        begin
                            cmd.cap_hit = 1'b1;
                            cmd.pos_ld  = 1'b1;
                            cmd.pos_sel = POS_HIT;
                            cmd.ptr_ld  = 1'b1;
                            cmd.ptr_sel = PTR_HIT_NEXT;
                            state_next  = S_SHIFT_DN;
                        end
                        default:
                        begin
                            cmd.cap_hit = 1'b1;
                            state_next  = S_FINISH;
                        end
                    endcase
                end
                else if (stat.miss)
                begin
                    cmd.st_ld   = 1'b1;
                    cmd.st_code = ST_MISSING;
                    state_next  = S_FINISH;
                end
                else if (stat.ptr_lt_fill)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_mode = RD_FWD;
                end
            end

            // move entries at and above the insertion point up by one
            S_SHIFT_UP:
            begin
                cmd.wr_mode = WR_UP;
                if (stat.ptr_gt_pos)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_mode = RD_BACK;
                end
                else if (!stat.rd_vld)
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                cmd.wr_mode  = WR_ITEM;
                cmd.fill_inc = 1'b1;
                state_next   = S_FINISH;
            end

            S_FETCH:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = RD_POS;
                state_next  = S_FETCH_CAP;
            end

            S_FETCH_CAP:
            begin
                cmd.cap_hit = 1'b1;
                cmd.ptr_ld  = 1'b1;
                cmd.ptr_sel = PTR_POS_NEXT;
                state_next  = S_SHIFT_DN;
            end

            // move entries above the removal point down by one
            S_SHIFT_DN:
            begin
                cmd.wr_mode = WR_DOWN;
                if (stat.ptr_lt_fill)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_mode = RD_FWD;
                end
                else if (!stat.rd_vld)
                begin
                    cmd.fill_dec = 1'b1;
                    state_next   = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (stat.res_free)
                begin
                    cmd.res_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/oale_dpath.sv =====
// ----------------------------------------------------------------------------
// oale_dpath
// entry memory, pointers, fill count, match logic and response register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ordered_array_list_engine_macros.svh"

module oale_dpath
    import oale_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_word_t  req,
    input  logic       rsp_stall,
    output logic       rsp_valid,
    output rsp_word_t  rsp,
    input  oale_cmd_t  cmd,
    output oale_stat_t stat
);

    localparam int NAME_W = 8 * NAME_BYTES;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // entry storage
    logic [31:0]       mem_id   [DEPTH];
    logic [NAME_W-1:0] mem_name [DEPTH];

    req_word_t         item_reg;
    logic [31:0]       rd_id_reg;
    logic [NAME_W-1:0] rd_name_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_vld_reg;
    logic [CNT_W-1:0]  ptr_reg;
    logic [CNT_W-1:0]  ptr_next;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  pos_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [1:0]        st_reg;
    logic [1:0]        st_next;
    logic [31:0]       cap_id_reg;
    logic [31:0]       cap_id_next;
    logic [NAME_W-1:0] cap_name_reg;
    logic [NAME_W-1:0] cap_name_next;
    rsp_word_t         rsp_reg;
    rsp_word_t         rsp_next;
    logic              rsp_vld_reg;
    logic              rsp_vld_next;

    logic [CNT_W-1:0]  rd_idx_ext;
    logic [CNT_W-1:0]  hit_pos_next;
    logic [CNT_W-1:0]  rd_addr;
    logic              wr_en;
    logic [CNT_W-1:0]  wr_addr;
    logic [31:0]       wr_id;
    logic [NAME_W-1:0] wr_name;
    logic              id_eq_key;
    logic              name_eq_key;
    logic              id_eq_new;
    logic              name_eq_new;
    logic              match;
    logic              fill_zero;
    logic              fill_full;
    logic              hit;
    logic              res_free;

    assign rd_idx_ext   = CNT_W'(rd_idx_reg);
    assign hit_pos_next = rd_idx_ext + 1'b1;
    assign fill_zero    = (fill_reg == '0);
    assign fill_full    = (fill_reg == DEPTH_CNT);

    // compare the word just read against the request
    assign id_eq_key   = (rd_id_reg == item_reg.key_id);
    assign name_eq_key = (rd_name_reg == item_reg.key_name[NAME_W-1:0]);
    assign id_eq_new   = (rd_id_reg == item_reg.new_id);
    assign name_eq_new = (rd_name_reg == item_reg.new_name[NAME_W-1:0]);

    always_comb
    begin
        case (item_reg.opcode)
            OP_FIND_ID:   match = id_eq_key;
            OP_FIND_NAME: match = name_eq_key;
            OP_REM_ITEM:  match = id_eq_new && name_eq_new;
            default:      match = id_eq_key && name_eq_key;
        endcase
    end

    assign hit = rd_vld_reg && match;

    // read address
    always_comb
    begin
        case (cmd.rd_mode)
            RD_BACK: rd_addr = ptr_reg - 1'b1;
            RD_POS:  rd_addr = pos_reg;
            default: rd_addr = ptr_reg;
        endcase
    end

    // write address and data
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_id   = rd_id_reg;
        wr_name = rd_name_reg;
        case (cmd.wr_mode)
            WR_UP:
            begin
                wr_en   = rd_vld_reg;
                wr_addr = hit_pos_next;
            end
            WR_DOWN:
            begin
                wr_en   = rd_vld_reg;
                wr_addr = rd_idx_ext - 1'b1;
            end
            WR_ITEM:
            begin
                wr_en   = 1'b1;
                wr_id   = item_reg.new_id;
                wr_name = item_reg.new_name[NAME_W-1:0];
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_id[wr_addr[IDX_W-1:0]]   <= wr_id;
            mem_name[wr_addr[IDX_W-1:0]] <= wr_name;
        end
        if (cmd.rd_en)
        begin
            rd_id_reg   <= mem_id[rd_addr[IDX_W-1:0]];
            rd_name_reg <= mem_name[rd_addr[IDX_W-1:0]];
            rd_idx_reg  <= rd_addr[IDX_W-1:0];
        end
    end

    // pointer, position and fill count
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.ptr_ld)
        begin
            case (cmd.ptr_sel)
                PTR_FILL:     ptr_next = fill_reg;
                PTR_HIT_NEXT: ptr_next = hit_pos_next;
                PTR_POS_NEXT: ptr_next = pos_reg + 1'b1;
                default:      ptr_next = '0;
            endcase
        end
        else if (cmd.rd_en)
        begin
            case (cmd.rd_mode)
                RD_BACK: ptr_next = ptr_reg - 1'b1;
                RD_FWD:  ptr_next = ptr_reg + 1'b1;
                default: ptr_next = ptr_reg;
            endcase
        end

        pos_next = pos_reg;
        if (cmd.pos_ld)
        begin
            case (cmd.pos_sel)
                POS_FILL:     pos_next = fill_reg;
                POS_LAST:     pos_next = fill_reg - 1'b1;
                POS_HIT:      pos_next = rd_idx_ext;
                POS_HIT_NEXT: pos_next = hit_pos_next;
                default:      pos_next = '0;
            endcase
        end

        fill_next = fill_reg;
        if (cmd.fill_inc)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd.fill_dec)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // status code and captured entry
    always_comb
    begin
        st_next       = cmd.st_ld ? cmd.st_code : st_reg;
        cap_id_next   = cap_id_reg;
        cap_name_next = cap_name_reg;
        if (cmd.load)
        begin
            cap_id_next   = '0;
            cap_name_next = '0;
        end
        else if (cmd.cap_hit)
        begin
            cap_id_next   = rd_id_reg;
            cap_name_next = rd_name_reg;
        end
    end

    // response word
    assign res_free = !rsp_vld_reg || !rsp_stall;

    always_comb
    begin
        rsp_next     = rsp_reg;
        rsp_vld_next = rsp_vld_reg && rsp_stall;
        if (cmd.res_ld)
        begin
            rsp_vld_next         = 1'b1;
            rsp_next.status      = st_reg;
            rsp_next.entry_count = 8'(fill_reg);
            if (st_reg == ST_OK)
            begin
                rsp_next.out_id   = cap_id_reg;
                rsp_next.out_name = 64'(cap_name_reg);
            end
            else
            begin
                rsp_next.out_id   = ID_FAIL;
                rsp_next.out_name = 64'(NA_TEXT[NAME_W-1:0]);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            ptr_reg     <= '0;
            pos_reg     <= '0;
            fill_reg    <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= cmd.rd_en;
            ptr_reg     <= ptr_next;
            pos_reg     <= pos_next;
            fill_reg    <= fill_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        st_reg       <= st_next;
        cap_id_reg   <= cap_id_next;
        cap_name_reg <= cap_name_next;
        rsp_reg      <= rsp_next;
    end

    // status to the controller
    always_comb
    begin
        stat.opcode      = item_reg.opcode;
        stat.fill_zero   = fill_zero;
        stat.fill_full   = fill_full;
        stat.hit         = hit;
        stat.miss        = !hit && (fill_zero || (rd_vld_reg && (hit_pos_next == fill_reg)));
        stat.ptr_lt_fill = (ptr_reg < fill_reg);
        stat.ptr_gt_pos  = (ptr_reg > pos_reg);
        stat.rd_vld      = rd_vld_reg;
        stat.res_free    = res_free;
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    // checks
    `OALE_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= DEPTH_CNT, "fill count beyond depth")
    `OALE_ASSERT_NOW(a_item_not_full, clk, rst_n, cmd.wr_mode == WR_ITEM, !fill_full, "insert write into full list")
    `OALE_ASSERT_NOW(a_fwd_in_list, clk, rst_n, cmd.rd_en && cmd.rd_mode == RD_FWD, ptr_reg < fill_reg, "forward read past last entry")
    `OALE_ASSERT_NOW(a_up_above_pos, clk, rst_n, cmd.wr_mode == WR_UP && rd_vld_reg, rd_idx_ext >= pos_reg, "shift up below insertion point")
    `OALE_ASSERT_NEXT(a_fetch_held, clk, rst_n, cmd.rd_en && cmd.rd_mode == RD_POS, rd_idx_ext < fill_reg, "fetch of an entry not held")

endmodule

// ===== rtl/ordered_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// ordered list of id and name entries with insert, remove and search
// ----------------------------------------------------------------------------
// Each request word runs to completion before the next is taken. Searches
// read the entry memory one entry a cycle from the front until a match, and
// inserts and removals then move every entry behind the point by one place,
// one entry a cycle through the single read and single write port of the
// memory. The scan stops at the key and the shift starts there, so the two
// together visit each entry about once. A finished response waits in an
// output register while the next request is accepted. No clearing pass is
// needed after reset.
`timescale 1ns / 1ps

module ordered_array_list_engine
    import oale_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    oale_cmd_t  cmd;
    oale_stat_t stat;

    // sequencer
    oale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // storage and datapath
    oale_dpath #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== tb/sv/list_shadow_checker.sv =====
// ----------------------------------------------------------------------------
// list_shadow_checker
// keeps a shadow copy of the ordered list, predicts every response word from
// the accepted request words and compares the responses field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module list_shadow_checker
    import oale_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_word_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_word_t rsp,
    output int        mismatches,
    output int        words_waiting,
    output int        peak_fill,
    output int        full_refusals,
    output int        empty_refusals
);

    localparam logic [63:0] NAME_MASK =
        (NAME_BYTES >= 8) ? '1 : ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

    // shadow list contents
    logic [31:0] list_ids   [DEPTH];
    logic [63:0] list_names [DEPTH];
    int          fill;
    rsp_word_t   predicted_rsp [$];
    rsp_word_t   due;
    rsp_word_t   fresh;

    // index of the first entry holding both id and name, fill when absent
    function automatic int first_pair(input logic [31:0] id, input logic [63:0] name);
        int i;
        int pos;
        pos = fill;
        for (i = fill - 1; i >= 0; i--)
            if (list_ids[i] == id && list_names[i] == name)
                pos = i;
        return pos;
    endfunction

    // shift the tail up by one and place the entry at pos
    function automatic void open_slot(input int pos, input logic [31:0] id,
                                      input logic [63:0] name);
        int j;
        for (j = fill; j > pos; j--)
        begin
            list_ids[j]   = list_ids[j - 1];
            list_names[j] = list_names[j - 1];
        end
        list_ids[pos]   = id;
        list_names[pos] = name;
        fill++;
    endfunction

    // shift the tail down by one over pos
    function automatic void close_slot(input int pos);
        int j;
        for (j = pos; j + 1 < fill; j++)
        begin
            list_ids[j]   = list_ids[j + 1];
            list_names[j] = list_names[j + 1];
        end
        fill--;
    endfunction

    // one request word applied to the shadow list, giving its response word
    function automatic rsp_word_t apply_op(input req_word_t w);
        logic [63:0] nname;
        logic [63:0] kname;
        int          pos;
        int          i;
        rsp_word_t   r;
        nname    = w.new_name & NAME_MASK;
        kname    = w.key_name & NAME_MASK;
        r        = '0;
        r.status = ST_OK;
        case (w.opcode)
            OP_INS_FRONT, OP_INS_END:
            begin
                if (fill >= DEPTH)
                    r.status = ST_FULL;
                else
                    open_slot((w.opcode == OP_INS_FRONT) ? 0 : fill, w.new_id, nname);
            end
            OP_INS_AFTER, OP_INS_BEFORE:
            begin
                // key lookup comes before the full check
                pos = first_pair(w.key_id, kname);
                if (pos >= fill)
                    r.status = ST_MISSING;
                else if (fill >= DEPTH)
                    r.status = ST_FULL;
                else
                    open_slot((w.opcode == OP_INS_AFTER) ? pos + 1 : pos, w.new_id, nname);
            end
            OP_REM_FRONT, OP_REM_END:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    pos        = (w.opcode == OP_REM_FRONT) ? 0 : fill - 1;
                    r.out_id   = list_ids[pos];
                    r.out_name = list_names[pos];
                    close_slot(pos);
                end
            end
            OP_REM_ITEM:
            begin
                pos = first_pair(w.new_id, nname);
                if (pos >= fill)
                    r.status = ST_MISSING;
                else
                begin
                    r.out_id   = list_ids[pos];
                    r.out_name = list_names[pos];
                    close_slot(pos);
                end
            end
            OP_FIND_ID, OP_FIND_NAME:
            begin
                pos = fill;
                for (i = fill - 1; i >= 0; i--)
                    if ((w.opcode == OP_FIND_ID) ? (list_ids[i] == w.key_id)
                                                 : (list_names[i] == kname))
                        pos = i;
                if (pos >= fill)
                    r.status = ST_MISSING;
                else
                begin
                    r.out_id   = list_ids[pos];
                    r.out_name = list_names[pos];
                end
            end
            default:
            begin
                // undefined opcodes leave the list alone
            end
        endcase
        if (r.status != ST_OK)
        begin
            r.out_id   = ID_FAIL;
            r.out_name = NA_TEXT & NAME_MASK;
        end
        r.entry_count = 8'(fill);
        return r;
    endfunction

    // compare responses first so a word pushed in the same cycle cannot mask one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = 0;
            predicted_rsp.delete();
            mismatches     = 0;
            words_waiting  = 0;
            peak_fill      = 0;
            full_refusals  = 0;
            empty_refusals = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: response word with none expected: status %0d id %0d name %h count %0d",
                                 $realtime, rsp.status, rsp.out_id, rsp.out_name, rsp.entry_count);
                end
                else
                begin
                    due = predicted_rsp.pop_front();
                    if (rsp.status !== due.status || rsp.out_id !== due.out_id ||
                        rsp.out_name !== due.out_name || rsp.entry_count !== due.entry_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp/got status %0d/%0d id %0d/%0d name %h/%h count %0d/%0d",
                                     $realtime, due.status, rsp.status, due.out_id, rsp.out_id,
                                     due.out_name, rsp.out_name, due.entry_count, rsp.entry_count);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                fresh = apply_op(req);
                predicted_rsp.push_back(fresh);
                if (fresh.status == ST_FULL)
                    full_refusals++;
                if (fresh.status == ST_EMPTY)
                    empty_refusals++;
                if (fill > peak_fill)
                    peak_fill = fill;
            end
            words_waiting = predicted_rsp.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives request words into the ordered array list engine with random pacing
// and response stalls; a directed opening covers empty-list and boundary cases,
// then random fill, drain and mixed phases take the list between empty and full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import oale_pkg::*;

    localparam int          HOLD_CYCLES    = 600;
    localparam int          FIRST_HOLD_AT  = 150;
    localparam int          SECOND_HOLD_AT = 900;
    localparam int          SETTLE_CYCLES  = 2 * DEPTH_DEF + 40;
    localparam int          POOL_SIZE      = 6;
    localparam logic [31:0] ID_MIN         = 32'h8000_0000;
    localparam logic [31:0] ID_MAX         = 32'h7FFF_FFFF;
    localparam logic [3:0]  OP_TOP_CODE    = 4'hF;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_ANY
    } op_mix_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp;

    int mismatches;
    int words_waiting;
    int peak_fill;
    int full_refusals;
    int empty_refusals;
    int rsp_done   = 0;
    int burst_left = 0;
    int op_sent [16];

    logic [31:0] id_pool   [POOL_SIZE];
    logic [63:0] name_pool [POOL_SIZE];

    // clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    ordered_array_list_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    list_shadow_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .mismatches     (mismatches),
        .words_waiting  (words_waiting),
        .peak_fill      (peak_fill),
        .full_refusals  (full_refusals),
        .empty_refusals (empty_refusals)
    );

    // response words taken so far, paces the long hold-offs
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            rsp_done <= rsp_done + 1;
    end

    function automatic req_word_t make_word(input logic [3:0] op, input logic [31:0] nid,
                                            input logic [63:0] nname, input logic [31:0] kid,
                                            input logic [63:0] kname);
        req_word_t w;
        w.opcode   = op;
        w.new_id   = nid;
        w.new_name = nname;
        w.key_id   = kid;
        w.key_name = kname;
        return w;
    endfunction

    // mostly pool values so keys hit, sometimes fully random
    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 99) < 85)
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [63:0] pick_name();
        if ($urandom_range(0, 99) < 85)
            return name_pool[$urandom_range(0, POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [3:0] pick_opcode(input op_mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return 4'($urandom_range(OP_FIND_NAME + 1, OP_TOP_CODE));
        case (mix)
            MIX_FILL:
            begin
                if (r < 45)
                    return r[0] ? OP_INS_END : OP_INS_FRONT;
                if (r < 85)
                    return r[0] ? OP_INS_AFTER : OP_INS_BEFORE;
            end
            MIX_DRAIN:
            begin
                if (r < 70)
                    return r[0] ? OP_REM_END : OP_REM_FRONT;
                if (r < 88)
                    return OP_REM_ITEM;
            end
            default:
            begin
            end
        endcase
        return 4'($urandom_range(OP_INS_FRONT, OP_FIND_NAME));
    endfunction

    // one word, paced in bursts with random gaps, held until taken
    task automatic send_word(input req_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        burst_left--;
        op_sent[w.opcode]++;
    endtask

    // stop sending until every expected response word has come back
    task automatic drain_pause();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
        while (words_waiting != 0)
            @(negedge clk);
    endtask

    // receiver: changing stall styles, plus two long hold-offs
    initial
    begin
        int style;
        int span;
        int hold_mark;
        rsp_stall = 1'b0;
        style     = 0;
        span      = 0;
        hold_mark = FIRST_HOLD_AT;
        forever
        begin
            @(negedge clk);
            if (rsp_done >= hold_mark)
            begin
                rsp_stall <= 1'b1;
                hold_mark = (hold_mark == FIRST_HOLD_AT) ? SECOND_HOLD_AT : 32'h7FFF_FFFF;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (span == 0)
            begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(16, 128);
            end
            span--;
            case (style)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                default: rsp_stall <= ((span % 8) < 3);
            endcase
        end
    end

    // stimulus and verdict
    initial
    begin
        int      i;
        int      round;
        int      ph;
        int      ins_cnt;
        int      rem_cnt;
        int      find_cnt;
        int      odd_cnt;
        op_mix_t mix;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        for (i = 0; i < 16; i++)
            op_sent[i] = 0;
        id_pool[0]   = ID_MIN;
        id_pool[1]   = ID_MAX;
        name_pool[0] = '0;
        name_pool[1] = '1;
        for (i = 2; i < POOL_SIZE; i++)
        begin
            id_pool[i]   = $urandom;
            name_pool[i] = {$urandom, $urandom};
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list: every removal and search fails, keyed inserts miss
        send_word(make_word(OP_REM_FRONT, ID_MIN, '0, ID_MIN, '0));
        send_word(make_word(OP_REM_END, ID_MAX, '1, ID_MAX, '1));
        send_word(make_word(OP_REM_ITEM, ID_MIN, '0, ID_MIN, '0));
        send_word(make_word(OP_FIND_ID, ID_MIN, '0, ID_MIN, '0));
        send_word(make_word(OP_FIND_NAME, ID_MIN, '0, ID_MIN, '0));
        send_word(make_word(OP_INS_AFTER, ID_MAX, '1, ID_MIN, '0));
        send_word(make_word(OP_INS_BEFORE, ID_MAX, '1, ID_MIN, '0));
        send_word(make_word(4'(OP_FIND_NAME + 1), ID_MAX, '1, ID_MAX, '1));

        // extremes in, keyed inserts on both ends, partial key miss
        send_word(make_word(OP_INS_END, ID_MIN, '0, ID_MAX, '1));
        send_word(make_word(OP_INS_FRONT, ID_MAX, '1, ID_MIN, '0));
        send_word(make_word(OP_INS_AFTER, '0, name_pool[2], ID_MAX, '1));
        send_word(make_word(OP_INS_BEFORE, ID_FAIL, NA_TEXT, ID_MIN, '0));
        send_word(make_word(OP_INS_AFTER, id_pool[2], name_pool[3], ID_MIN, '1));

        // searches and removals, hits and misses
        send_word(make_word(OP_FIND_ID, '0, '0, ID_MIN, '1));
        send_word(make_word(OP_FIND_NAME, '0, '0, ID_MIN, '1));
        send_word(make_word(OP_FIND_ID, '0, '0, id_pool[3], '0));
        send_word(make_word(OP_FIND_NAME, '0, '0, ID_MIN, name_pool[4]));
        send_word(make_word(OP_REM_ITEM, ID_MAX, '0, '0, '0));
        send_word(make_word(OP_REM_ITEM, '0, name_pool[2], '0, '0));
        send_word(make_word(OP_REM_END, '0, '0, '0, '0));
        send_word(make_word(OP_REM_FRONT, '0, '0, '0, '0));
        send_word(make_word(OP_TOP_CODE, '1, '1, '1, '1));
        send_word(make_word(OP_FIND_NAME, '0, '0, '0, NA_TEXT));
        drain_pause();

        // random phases swing the list between full and empty
        for (round = 0; round < 2; round++)
        begin
            for (ph = 0; ph < 4; ph++)
            begin
                mix = (ph == 0) ? MIX_FILL : (ph == 2) ? MIX_DRAIN : MIX_ANY;
                repeat ((mix == MIX_ANY) ? 200 : 200)
                    send_word(make_word(pick_opcode(mix), pick_id(), pick_name(),
                                        pick_id(), pick_name()));
                if (ph == 1)
                    drain_pause();
            end
        end

        // wind down
        drain_pause();
        repeat (SETTLE_CYCLES) @(negedge clk);

        ins_cnt  = op_sent[OP_INS_FRONT] + op_sent[OP_INS_END] +
                   op_sent[OP_INS_AFTER] + op_sent[OP_INS_BEFORE];
        rem_cnt  = op_sent[OP_REM_FRONT] + op_sent[OP_REM_END] + op_sent[OP_REM_ITEM];
        find_cnt = op_sent[OP_FIND_ID] + op_sent[OP_FIND_NAME];
        odd_cnt  = 0;
        for (i = OP_FIND_NAME + 1; i <= OP_TOP_CODE; i++)
            odd_cnt += op_sent[i];
        $display("request words: %0d inserts, %0d removals, %0d searches, %0d undefined",
                 ins_cnt, rem_cnt, find_cnt, odd_cnt);
        $display("list peak %0d entries, %0d inserts refused as full, %0d removals on empty",
                 peak_fill, full_refusals, empty_refusals);
        if (mismatches == 0 && words_waiting == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/oale_pkg.sv
rtl/oale_ctrl.sv
rtl/oale_dpath.sv
rtl/ordered_array_list_engine.sv
tb/sv/list_shadow_checker.sv
tb/sv/tb.sv
